[src/point_triangle_distance_2d_macros.svh]
// Assertion macros shared by the checker of the triangle distance block.
// Expects clk and rst_n in scope at the point of use.
`ifndef POINT_TRIANGLE_DISTANCE_2D_MACROS_SVH
`define POINT_TRIANGLE_DISTANCE_2D_MACROS_SVH

// same-cycle implication
`define PTD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PTD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/ptd_pkg.sv]
// Package for the triangle distance block: request/result structs,
// register indexes, reset values and region codes. No dependencies.
`timescale 1ns / 1ps

package ptd_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int FIELD_W         = 16;
  localparam int CFG_IDX_W       = 3;
  localparam int NUM_CFG         = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_V0_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_V0_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_V1_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_V1_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_V2_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_V2_Y = 3'd5;

  localparam logic [FIELD_W-1:0] V0_X_RST = 16'd0;
  localparam logic [FIELD_W-1:0] V0_Y_RST = 16'd0;
  localparam logic [FIELD_W-1:0] V1_X_RST = 16'd256;
  localparam logic [FIELD_W-1:0] V1_Y_RST = 16'd0;
  localparam logic [FIELD_W-1:0] V2_X_RST = 16'd0;
  localparam logic [FIELD_W-1:0] V2_Y_RST = 16'd256;

  localparam logic [2:0] RGN_INSIDE  = 3'd0;
  localparam logic [2:0] RGN_EDGE_12 = 3'd1;
  localparam logic [2:0] RGN_VERT_2  = 3'd2;
  localparam logic [2:0] RGN_EDGE_02 = 3'd3;
  localparam logic [2:0] RGN_VERT_0  = 3'd4;
  localparam logic [2:0] RGN_EDGE_01 = 3'd5;
  localparam logic [2:0] RGN_VERT_1  = 3'd6;

  typedef struct packed {
    logic signed [FIELD_W-1:0] query_x;
    logic signed [FIELD_W-1:0] query_y;
  } ptd_in_t;

  typedef struct packed {
    logic [16:0] distance;
    logic [32:0] squared_distance;
    logic [2:0]  region;
    logic        degenerate;
  } ptd_out_t;

endpackage

[src/point_triangle_distance_2d.sv]
// Point to triangle distance, fully pipelined, one request per cycle.
// Coordinates are used at EW = min(COORD_WIDTH,16) bits.
// Depth is set by the bit-per-stage divider (edge distance) and root stages.
// Throughput one request per clock; an output stall while out_valid is high freezes the whole pipe.
// Synchronous active-low reset clears valid bits and loads default vertices.
`timescale 1ns / 1ps

module point_triangle_distance_2d
  import ptd_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [FIELD_W-1:0]   cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ptd_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ptd_out_t             out_data
);

  localparam int EW  = (COORD_WIDTH > FIELD_W) ? FIELD_W : COORD_WIDTH;
  localparam int DW  = EW + 1;
  localparam int PW  = 2 * DW;
  localparam int SSW = PW + 1;
  localparam int QW  = PW;
  localparam int NW  = 4 * DW;
  localparam int RMW = DW + 1;
  localparam int RSW = DW + 3;
  localparam int P_IDX [3] = '{0, 0, 1};
  localparam int R_IDX [3] = '{1, 2, 2};

  function automatic logic signed [DW-1:0] sx(input logic [FIELD_W-1:0] v);
    sx = $signed({v[EW-1], v[EW-1:0]});
  endfunction

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = out_valid && out_stall;

  // vertex registers
  logic [FIELD_W-1:0] cfg_r [NUM_CFG];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r[CFG_V0_X] <= V0_X_RST;
      cfg_r[CFG_V0_Y] <= V0_Y_RST;
      cfg_r[CFG_V1_X] <= V1_X_RST;
      cfg_r[CFG_V1_Y] <= V1_Y_RST;
      cfg_r[CFG_V2_X] <= V2_X_RST;
      cfg_r[CFG_V2_Y] <= V2_Y_RST;
    end else if (cfg_wr_en) begin
      case (cfg_idx)
        CFG_V0_X: cfg_r[CFG_V0_X] <= cfg_data;
        CFG_V0_Y: cfg_r[CFG_V0_Y] <= cfg_data;
        CFG_V1_X: cfg_r[CFG_V1_X] <= cfg_data;
        CFG_V1_Y: cfg_r[CFG_V1_Y] <= cfg_data;
        CFG_V2_X: cfg_r[CFG_V2_X] <= cfg_data;
        CFG_V2_Y: cfg_r[CFG_V2_Y] <= cfg_data;
        default: ;
      endcase
    end
  end

  logic signed [DW-1:0] qx, qy;
  logic signed [DW-1:0] vx [3];
  logic signed [DW-1:0] vy [3];

  always_comb begin
    qx    = sx(in_data.query_x);
    qy    = sx(in_data.query_y);
    vx[0] = sx(cfg_r[CFG_V0_X]);
    vy[0] = sx(cfg_r[CFG_V0_Y]);
    vx[1] = sx(cfg_r[CFG_V1_X]);
    vy[1] = sx(cfg_r[CFG_V1_Y]);
    vx[2] = sx(cfg_r[CFG_V2_X]);
    vy[2] = sx(cfg_r[CFG_V2_Y]);
  end

  // s1: differences; edges are V0-V1, V0-V2, V1-V2
  logic                 s1_vld_r;
  logic signed [DW-1:0] s1_dx_r [3];
  logic signed [DW-1:0] s1_dy_r [3];
  logic signed [DW-1:0] s1_ex_r [3];
  logic signed [DW-1:0] s1_ey_r [3];
  logic signed [DW-1:0] s1_fx_r [3];
  logic signed [DW-1:0] s1_fy_r [3];
  logic signed [DW-1:0] s1_gx_r, s1_gy_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int e = 0; e < 3; e++) begin
        s1_dx_r[e] <= qx - vx[P_IDX[e]];
        s1_dy_r[e] <= qy - vy[P_IDX[e]];
        s1_ex_r[e] <= vx[R_IDX[e]] - vx[P_IDX[e]];
        s1_ey_r[e] <= vy[R_IDX[e]] - vy[P_IDX[e]];
        s1_fx_r[e] <= qx - vx[R_IDX[e]];
        s1_fy_r[e] <= qy - vy[R_IDX[e]];
      end
      s1_gx_r <= vx[0] - qx;
      s1_gy_r <= vy[0] - qy;
    end
  end

  // s2: products
  logic                 s2_vld_r;
  logic signed [PW-1:0] s2_ddx_r [3];
  logic signed [PW-1:0] s2_ddy_r [3];
  logic signed [PW-1:0] s2_llx_r [3];
  logic signed [PW-1:0] s2_lly_r [3];
  logic signed [PW-1:0] s2_ffx_r [3];
  logic signed [PW-1:0] s2_ffy_r [3];
  logic signed [PW-1:0] s2_ua_r [3];
  logic signed [PW-1:0] s2_ub_r [3];
  logic signed [PW-1:0] s2_ca_r [3];
  logic signed [PW-1:0] s2_cb_r [3];
  logic signed [PW-1:0] s2_xa_r, s2_xb_r, s2_sa_r, s2_sb_r, s2_ta_r, s2_tb_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int e = 0; e < 3; e++) begin
        s2_ddx_r[e] <= s1_dx_r[e] * s1_dx_r[e];
        s2_ddy_r[e] <= s1_dy_r[e] * s1_dy_r[e];
        s2_llx_r[e] <= s1_ex_r[e] * s1_ex_r[e];
        s2_lly_r[e] <= s1_ey_r[e] * s1_ey_r[e];
        s2_ffx_r[e] <= s1_fx_r[e] * s1_fx_r[e];
        s2_ffy_r[e] <= s1_fy_r[e] * s1_fy_r[e];
        s2_ua_r[e]  <= s1_dx_r[e] * s1_ex_r[e];
        s2_ub_r[e]  <= s1_dy_r[e] * s1_ey_r[e];
        s2_ca_r[e]  <= s1_dx_r[e] * s1_ey_r[e];
        s2_cb_r[e]  <= s1_dy_r[e] * s1_ex_r[e];
      end
      s2_xa_r <= s1_ex_r[0] * s1_ey_r[1];
      s2_xb_r <= s1_ey_r[0] * s1_ex_r[1];
      s2_sa_r <= s1_ex_r[1] * s1_gy_r;
      s2_sb_r <= s1_ey_r[1] * s1_gx_r;
      s2_ta_r <= s1_gx_r * s1_ey_r[0];
      s2_tb_r <= s1_gy_r * s1_ex_r[0];
    end
  end

  // s3: sums
  logic                  s3_vld_r;
  logic [PW-1:0]         s3_dd_r [3];
  logic [PW-1:0]         s3_len_r [3];
  logic [PW-1:0]         s3_ff_r [3];
  logic signed [SSW-1:0] s3_u_r [3];
  logic signed [SSW-1:0] s3_cr_r [3];
  logic signed [SSW-1:0] s3_x_r, s3_cs_r, s3_ct_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int e = 0; e < 3; e++) begin
        s3_dd_r[e]  <= $unsigned(s2_ddx_r[e]) + $unsigned(s2_ddy_r[e]);
        s3_len_r[e] <= $unsigned(s2_llx_r[e]) + $unsigned(s2_lly_r[e]);
        s3_ff_r[e]  <= $unsigned(s2_ffx_r[e]) + $unsigned(s2_ffy_r[e]);
        s3_u_r[e]   <= SSW'(s2_ua_r[e]) + SSW'(s2_ub_r[e]);
        s3_cr_r[e]  <= SSW'(s2_ca_r[e]) - SSW'(s2_cb_r[e]);
      end
      s3_x_r  <= SSW'(s2_xa_r) - SSW'(s2_xb_r);
      s3_cs_r <= SSW'(s2_sa_r) - SSW'(s2_sb_r);
      s3_ct_r <= SSW'(s2_ta_r) - SSW'(s2_tb_r);
    end
  end

  // s4: segment case per edge, orientation fix
  logic                  s4_vld_r;
  logic [PW-1:0]         s4_alt_r [3];
  logic                  s4_div_r [3];
  logic [PW-1:0]         s4_d_r [3];
  logic [PW-1:0]         s4_a_r [3];
  logic signed [SSW-1:0] s4_x_r, s4_cs_r, s4_ct_r;
  logic                  s4_deg_r;
  logic signed [SSW-1:0] s4_cr_abs [3];
  logic                  s4_near_p [3];
  logic                  s4_near_r [3];

  always_comb begin
    for (int e = 0; e < 3; e++) begin
      s4_cr_abs[e] = s3_cr_r[e][SSW-1] ? -s3_cr_r[e] : s3_cr_r[e];
      s4_near_p[e] = (s3_len_r[e] == '0) || (s3_u_r[e] <= 0);
      s4_near_r[e] = s3_u_r[e] >= $signed({1'b0, s3_len_r[e]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int e = 0; e < 3; e++) begin
        s4_alt_r[e] <= s4_near_p[e] ? s3_dd_r[e] : s3_ff_r[e];
        s4_div_r[e] <= !s4_near_p[e] && !s4_near_r[e];
        s4_d_r[e]   <= s3_len_r[e];
        s4_a_r[e]   <= s4_cr_abs[e][PW-1:0];
      end
      s4_deg_r <= (s3_x_r == '0);
      s4_x_r   <= s3_x_r[SSW-1] ? -s3_x_r : s3_x_r;
      s4_cs_r  <= s3_x_r[SSW-1] ? -s3_cs_r : s3_cs_r;
      s4_ct_r  <= s3_x_r[SSW-1] ? -s3_ct_r : s3_ct_r;
    end
  end

  // s5: partial products of |cross|^2, region
  logic                s5_vld_r;
  logic [PW-1:0]       s5_ll_r [3];
  logic [PW-1:0]       s5_lh_r [3];
  logic [PW-1:0]       s5_hh_r [3];
  logic [PW-1:0]       s5_alt_r [3];
  logic                s5_div_r [3];
  logic [PW-1:0]       s5_d_r [3];
  logic [2:0]          s5_rgn_r;
  logic                s5_deg_r;
  logic signed [SSW:0] s5_sum;
  logic                s5_le;
  logic [2:0]          s5_rgn_nxt;

  always_comb begin
    s5_sum = {s4_cs_r[SSW-1], s4_cs_r} + {s4_ct_r[SSW-1], s4_ct_r};
    s5_le  = s5_sum <= $signed({s4_x_r[SSW-1], s4_x_r});
    if (s5_le) begin
      if (s4_cs_r < 0) s5_rgn_nxt = (s4_ct_r < 0) ? RGN_VERT_0 : RGN_EDGE_02;
      else             s5_rgn_nxt = (s4_ct_r < 0) ? RGN_EDGE_01 : RGN_INSIDE;
    end else begin
      if (s4_cs_r < 0) s5_rgn_nxt = RGN_VERT_2;
      else             s5_rgn_nxt = (s4_ct_r < 0) ? RGN_VERT_1 : RGN_EDGE_12;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int e = 0; e < 3; e++) begin
        s5_ll_r[e]  <= s4_a_r[e][DW-1:0] * s4_a_r[e][DW-1:0];
        s5_lh_r[e]  <= s4_a_r[e][DW-1:0] * s4_a_r[e][PW-1:DW];
        s5_hh_r[e]  <= s4_a_r[e][PW-1:DW] * s4_a_r[e][PW-1:DW];
        s5_alt_r[e] <= s4_alt_r[e];
        s5_div_r[e] <= s4_div_r[e];
        s5_d_r[e]   <= s4_d_r[e];
      end
      s5_rgn_r <= s5_rgn_nxt;
      s5_deg_r <= s4_deg_r;
    end
  end

  // divider: floor(cross^2 / len), one quotient bit per stage
  logic [PW-1:0] dv_rem_r [3][QW+1];
  logic [PW-1:0] dv_nlo_r [3][QW+1];
  logic [QW-1:0] dv_q_r   [3][QW+1];
  logic [PW-1:0] dv_d_r   [3][QW+1];
  logic [PW-1:0] dv_alt_r [3][QW+1];
  logic          dv_div_r [3][QW+1];
  logic [PW-1:0] dv_rem_nxt [3][QW+1];
  logic [PW-1:0] dv_nlo_nxt [3][QW+1];
  logic [QW-1:0] dv_q_nxt   [3][QW+1];
  logic [PW-1:0] dv_d_nxt   [3][QW+1];
  logic [PW-1:0] dv_alt_nxt [3][QW+1];
  logic          dv_div_nxt [3][QW+1];
  logic [2:0]    dv_rgn_r [QW+1];
  logic          dv_deg_r [QW+1];
  logic          dv_vld_r [QW+1];
  logic [NW-1:0] dv_num [3];
  logic [PW:0]   dv_t [3][QW];
  logic          dv_ge [3][QW];

  always_comb begin
    for (int e = 0; e < 3; e++) begin
      dv_num[e] = {s5_hh_r[e], {PW{1'b0}}} + (NW'(s5_lh_r[e]) << (DW + 1))
                  + NW'(s5_ll_r[e]);
      dv_rem_nxt[e][0] = dv_num[e][NW-1:PW];
      dv_nlo_nxt[e][0] = dv_num[e][PW-1:0];
      dv_q_nxt[e][0]   = '0;
      dv_d_nxt[e][0]   = s5_d_r[e];
      dv_alt_nxt[e][0] = s5_alt_r[e];
      dv_div_nxt[e][0] = s5_div_r[e];
      for (int i = 0; i < QW; i++) begin
        dv_t[e][i]  = {dv_rem_r[e][i], dv_nlo_r[e][i][QW-1-i]};
        dv_ge[e][i] = dv_t[e][i] >= {1'b0, dv_d_r[e][i]};
        dv_rem_nxt[e][i+1] = dv_ge[e][i] ? PW'(dv_t[e][i] - {1'b0, dv_d_r[e][i]})
                                         : dv_t[e][i][PW-1:0];
        dv_q_nxt[e][i+1]   = {dv_q_r[e][i][QW-2:0], dv_ge[e][i]};
        dv_nlo_nxt[e][i+1] = dv_nlo_r[e][i];
        dv_d_nxt[e][i+1]   = dv_d_r[e][i];
        dv_alt_nxt[e][i+1] = dv_alt_r[e][i];
        dv_div_nxt[e][i+1] = dv_div_r[e][i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int e = 0; e < 3; e++) begin
        for (int i = 0; i <= QW; i++) begin
          dv_rem_r[e][i] <= dv_rem_nxt[e][i];
          dv_nlo_r[e][i] <= dv_nlo_nxt[e][i];
          dv_q_r[e][i]   <= dv_q_nxt[e][i];
          dv_d_r[e][i]   <= dv_d_nxt[e][i];
          dv_alt_r[e][i] <= dv_alt_nxt[e][i];
          dv_div_r[e][i] <= dv_div_nxt[e][i];
        end
      end
      dv_rgn_r[0] <= s5_rgn_r;
      dv_deg_r[0] <= s5_deg_r;
      for (int i = 0; i < QW; i++) begin
        dv_rgn_r[i+1] <= dv_rgn_r[i];
        dv_deg_r[i+1] <= dv_deg_r[i];
      end
    end
  end

  // minimum over edges, then square root two bits per stage
  logic [PW-1:0]  rt_n_r    [DW+1];
  logic [RMW-1:0] rt_rem_r  [DW+1];
  logic [DW-1:0]  rt_root_r [DW+1];
  logic [2:0]     rt_rgn_r  [DW+1];
  logic           rt_deg_r  [DW+1];
  logic           rt_vld_r  [DW+1];
  logic [PW-1:0]  rt_n_nxt    [DW+1];
  logic [RMW-1:0] rt_rem_nxt  [DW+1];
  logic [DW-1:0]  rt_root_nxt [DW+1];
  logic [2:0]     rt_rgn_nxt  [DW+1];
  logic [PW-1:0]  mn_cand [3];
  logic [PW-1:0]  mn_val;
  logic [RSW-1:0] rt_tr    [DW];
  logic [RSW-1:0] rt_trial [DW];
  logic           rt_ge    [DW];

  always_comb begin
    for (int e = 0; e < 3; e++) begin
      mn_cand[e] = dv_div_r[e][QW] ? dv_q_r[e][QW] : dv_alt_r[e][QW];
    end
    mn_val = mn_cand[0];
    if (mn_cand[1] < mn_val) mn_val = mn_cand[1];
    if (mn_cand[2] < mn_val) mn_val = mn_cand[2];
    rt_n_nxt[0]    = (dv_deg_r[QW] || dv_rgn_r[QW] == RGN_INSIDE) ? '0 : mn_val;
    rt_rgn_nxt[0]  = dv_deg_r[QW] ? RGN_INSIDE : dv_rgn_r[QW];
    rt_rem_nxt[0]  = '0;
    rt_root_nxt[0] = '0;
    for (int j = 0; j < DW; j++) begin
      rt_tr[j]    = {rt_rem_r[j], rt_n_r[j][PW-1-2*j -: 2]};
      rt_trial[j] = RSW'({rt_root_r[j], 2'b01});
      rt_ge[j]    = rt_tr[j] >= rt_trial[j];
      rt_rem_nxt[j+1]  = rt_ge[j] ? RMW'(rt_tr[j] - rt_trial[j]) : rt_tr[j][RMW-1:0];
      rt_root_nxt[j+1] = {rt_root_r[j][DW-2:0], rt_ge[j]};
      rt_n_nxt[j+1]    = rt_n_r[j];
      rt_rgn_nxt[j+1]  = rt_rgn_r[j];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j <= DW; j++) begin
        rt_n_r[j]    <= rt_n_nxt[j];
        rt_rem_r[j]  <= rt_rem_nxt[j];
        rt_root_r[j] <= rt_root_nxt[j];
        rt_rgn_r[j]  <= rt_rgn_nxt[j];
      end
      rt_deg_r[0] <= dv_deg_r[QW];
      for (int j = 0; j < DW; j++) begin
        rt_deg_r[j+1] <= rt_deg_r[j];
      end
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
      for (int i = 0; i <= QW; i++) dv_vld_r[i] <= 1'b0;
      for (int j = 0; j <= DW; j++) rt_vld_r[j] <= 1'b0;
    end else if (en) begin
      s1_vld_r    <= in_valid;
      s2_vld_r    <= s1_vld_r;
      s3_vld_r    <= s2_vld_r;
      s4_vld_r    <= s3_vld_r;
      s5_vld_r    <= s4_vld_r;
      dv_vld_r[0] <= s5_vld_r;
      for (int i = 0; i < QW; i++) dv_vld_r[i+1] <= dv_vld_r[i];
      rt_vld_r[0] <= dv_vld_r[QW];
      for (int j = 0; j < DW; j++) rt_vld_r[j+1] <= rt_vld_r[j];
    end
  end

  assign out_valid                 = rt_vld_r[DW];
  assign out_data.distance         = 17'(rt_root_r[DW]);
  assign out_data.squared_distance = 33'(rt_n_r[DW]);
  assign out_data.region           = rt_rgn_r[DW];
  assign out_data.degenerate       = rt_deg_r[DW];

endmodule

[src/ptd_checker.sv]
// Port-level checks for the triangle distance block, bound to the top level.
// Depends on ptd_pkg and point_triangle_distance_2d_macros.svh.
`timescale 1ns / 1ps
`include "point_triangle_distance_2d_macros.svh"

module ptd_checker
  import ptd_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input ptd_out_t out_data
);

  `PTD_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
  `PTD_ASSERT_IMP(a_degen_zero, out_valid && out_data.degenerate, out_data.distance == 17'd0 && out_data.squared_distance == 33'd0 && out_data.region == RGN_INSIDE, "degenerate result not zero")
  `PTD_ASSERT_IMP(a_inside_zero, out_valid && out_data.region == RGN_INSIDE, out_data.squared_distance == 33'd0 && out_data.distance == 17'd0, "interior result has distance")
  `PTD_ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall, "request stalled without output stall")

endmodule

bind point_triangle_distance_2d ptd_checker u_ptd_checker (.*);

[tb/sv/point_triangle_distance_2d_test.sv]
// Self-checking testbench for point_triangle_distance_2d: query points are sent
// against several triangles and each result is checked against a local predictor.
// Depends on ptd_pkg and the point_triangle_distance_2d RTL.
`timescale 1ns / 1ps

module point_triangle_distance_2d_test;
  import ptd_pkg::*;

  localparam int PIPE_DRAIN = 80;
  localparam int WATCHDOG_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [FIELD_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  ptd_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ptd_out_t out_data;

  logic signed [FIELD_W-1:0] vertex_regs [NUM_CFG];
  ptd_out_t expected_results[$];
  int errors = 0;
  int queries_sent = 0;
  int results_checked = 0;
  int degenerate_seen = 0;
  int region_hits [7];
  int burst_left = 0;
  int idle_cnt = 0;

  point_triangle_distance_2d uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // floor of squared distance from q to segment p-r
  function automatic longint unsigned segment_sq(longint qx, longint qy, longint px,
                                                 longint py, longint rx, longint ry);
    longint dx, dy, ex, ey, u, cr, len;
    logic [127:0] num;
    dx = qx - px; dy = qy - py; ex = rx - px; ey = ry - py;
    len = ex * ex + ey * ey;
    u = dx * ex + dy * ey;
    if (len == 0 || u <= 0) return dx * dx + dy * dy;
    if (u >= len) return (qx - rx) * (qx - rx) + (qy - ry) * (qy - ry);
    cr = dx * ey - dy * ex;
    if (cr < 0) cr = -cr;
    num = 128'(cr) * 128'(cr);
    return 64'(num / 128'(len));
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned r;
    r = 0;
    for (int b = 17; b >= 0; b--)
      if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= n) r = r | (64'd1 << b);
    return r;
  endfunction

  function automatic ptd_out_t predict_distance(ptd_in_t q);
    longint qx, qy, ax, ay, bx, by, cx, cy, e0x, e0y, e1x, e1y, dx, dy, det, cs, ct;
    longint unsigned sq, d;
    logic [2:0] rg;
    ptd_out_t r;
    qx = q.query_x; qy = q.query_y;
    ax = vertex_regs[CFG_V0_X]; ay = vertex_regs[CFG_V0_Y];
    bx = vertex_regs[CFG_V1_X]; by = vertex_regs[CFG_V1_Y];
    cx = vertex_regs[CFG_V2_X]; cy = vertex_regs[CFG_V2_Y];
    e0x = bx - ax; e0y = by - ay; e1x = cx - ax; e1y = cy - ay;
    dx = ax - qx; dy = ay - qy;
    det = e0x * e1y - e0y * e1x;
    r = '0;
    if (det == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    cs = e1x * dy - e1y * dx;
    ct = dx * e0y - dy * e0x;
    if (det < 0) begin
      det = -det; cs = -cs; ct = -ct;
    end
    if (cs + ct <= det) begin
      if (cs < 0) rg = (ct < 0) ? RGN_VERT_0 : RGN_EDGE_02;
      else rg = (ct < 0) ? RGN_EDGE_01 : RGN_INSIDE;
    end else begin
      if (cs < 0) rg = RGN_VERT_2;
      else rg = (ct < 0) ? RGN_VERT_1 : RGN_EDGE_12;
    end
    sq = 0;
    if (rg != RGN_INSIDE) begin
      sq = segment_sq(qx, qy, ax, ay, bx, by);
      d = segment_sq(qx, qy, ax, ay, cx, cy);
      if (d < sq) sq = d;
      d = segment_sq(qx, qy, bx, by, cx, cy);
      if (d < sq) sq = d;
    end
    r.distance = 17'(floor_sqrt(sq));
    r.squared_distance = 33'(sq);
    r.region = rg;
    return r;
  endfunction

  // scoreboard and watchdog
  always @(posedge clk) begin
    ptd_out_t exp_r;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d results outstanding", $time,
                 expected_results.size());
        $display("TB_ERROR");
        $finish;
      end
      if (in_valid && !in_stall) expected_results.push_back(predict_distance(in_data));
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %p", $time, out_data);
        end else begin
          exp_r = expected_results.pop_front();
          results_checked++;
          if (exp_r.degenerate) degenerate_seen++;
          else region_hits[exp_r.region]++;
          if (out_data.distance !== exp_r.distance) begin
            errors++;
            $display("%0t: distance exp %0d got %0d", $time, exp_r.distance,
                     out_data.distance);
          end
          if (out_data.squared_distance !== exp_r.squared_distance) begin
            errors++;
            $display("%0t: squared_distance exp %0d got %0d", $time,
                     exp_r.squared_distance, out_data.squared_distance);
          end
          if (out_data.region !== exp_r.region) begin
            errors++;
            $display("%0t: region exp %0d got %0d", $time, exp_r.region, out_data.region);
          end
          if (out_data.degenerate !== exp_r.degenerate) begin
            errors++;
            $display("%0t: degenerate exp %0d got %0d", $time, exp_r.degenerate,
                     out_data.degenerate);
          end
        end
      end
    end
  end

  // receiver stall pattern: calm stretches, light random stalls, heavy random stalls
  initial begin
    int mode, span;
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(32, 256);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0: out_stall = 1'b0;
          1: out_stall = ($urandom_range(0, 99) < 30);
          default: out_stall = ($urandom_range(0, 9) < 8);
        endcase
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [FIELD_W-1:0] val);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_idx = idx;
    cfg_data = val;
    if (idx < NUM_CFG) vertex_regs[idx] = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic set_triangle(int x0, int y0, int x1, int y1, int x2, int y2);
    write_reg(CFG_V0_X, 16'(x0)); write_reg(CFG_V0_Y, 16'(y0));
    write_reg(CFG_V1_X, 16'(x1)); write_reg(CFG_V1_Y, 16'(y1));
    write_reg(CFG_V2_X, 16'(x2)); write_reg(CFG_V2_Y, 16'(y2));
  endtask

  // holds valid across a burst; drops it only for a gap
  task automatic send_query(int x, int y);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    in_data.query_x = 16'(x);
    in_data.query_y = 16'(y);
    do @(posedge clk); while (in_stall);
    queries_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  task automatic test_reset_triangle();
    send_query(64, 64);      send_query(256, 256);   send_query(-256, 768);
    send_query(-256, 128);   send_query(-256, -256); send_query(128, -256);
    send_query(768, -256);   send_query(0, 0);       send_query(256, 0);
    send_query(0, 256);      send_query(128, 128);
    send_query(32767, 32767);   send_query(-32768, -32768);
    send_query(-32768, 32767);  send_query(32767, -32768);
    wait_drained();
  endtask

  task automatic test_extreme_triangle();
    set_triangle(32767, -32768, -32768, -32768, -32768, 32767);
    send_query(32767, 32767);  send_query(-32768, -32768);
    send_query(0, 0);          send_query(-32768, 32767);
    send_query(32767, -32768); send_query(-1, -1);
    wait_drained();
  endtask

  task automatic test_degenerate();
    set_triangle(0, 0, 256, 256, 512, 512);
    send_query(5, 9); send_query(-32768, 32767);
    wait_drained();
    set_triangle(100, -100, 100, -100, 100, -100);
    send_query(100, -100); send_query(0, 0);
    wait_drained();
  endtask

  task automatic test_unused_index();
    write_reg(CFG_IDX_W'(NUM_CFG), 16'hffff);
    write_reg('1, 16'h5a5a);
    set_triangle(0, 0, 256, 0, 0, 256);
    send_query(300, 300); send_query(-10, 20);
    wait_drained();
  endtask

  task automatic test_random_phases();
    int lo, hi, span, cx, cy;
    int v [6];
    for (int ph = 0; ph < 8; ph++) begin
      span = (ph % 3 == 2) ? 32767 : $urandom_range(16, 2048);
      cx = $urandom_range(0, 4095) - 2048;
      cy = $urandom_range(0, 4095) - 2048;
      foreach (v[i]) begin
        lo = ((i % 2) ? cy : cx) - span;
        hi = ((i % 2) ? cy : cx) + span;
        if (lo < -32768) lo = -32768;
        if (hi > 32767) hi = 32767;
        v[i] = $urandom_range(hi - lo) + lo;
      end
      if (ph == 5) begin
        v[4] = 2 * v[2] - v[0];
        v[5] = 2 * v[3] - v[1];
        if (v[4] > 32767 || v[4] < -32768 || v[5] > 32767 || v[5] < -32768) begin
          v[4] = v[2]; v[5] = v[3];
        end
      end
      set_triangle(v[0], v[1], v[2], v[3], v[4], v[5]);
      repeat (150) begin
        if ($urandom_range(0, 9) < 3)
          send_query(int'($signed(16'($urandom))), int'($signed(16'($urandom))));
        else begin
          lo = 2 * $urandom_range(0, 2);
          send_query(int'($signed(16'(v[lo] + $urandom_range(0, 1024) - 512))),
                     int'($signed(16'(v[lo + 1] + $urandom_range(0, 1024) - 512))));
        end
      end
      wait_drained();
    end
  endtask

  initial begin
    vertex_regs[CFG_V0_X] = V0_X_RST; vertex_regs[CFG_V0_Y] = V0_Y_RST;
    vertex_regs[CFG_V1_X] = V1_X_RST; vertex_regs[CFG_V1_Y] = V1_Y_RST;
    vertex_regs[CFG_V2_X] = V2_X_RST; vertex_regs[CFG_V2_Y] = V2_Y_RST;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    test_reset_triangle();
    test_extreme_triangle();
    test_degenerate();
    test_unused_index();
    test_random_phases();
    $display("Checked %0d of %0d queries over 13 triangle setups, %0d degenerate.",
             results_checked, queries_sent, degenerate_seen);
    $display("Region counts 0..6: %0d %0d %0d %0d %0d %0d %0d", region_hits[0],
             region_hits[1], region_hits[2], region_hits[3], region_hits[4],
             region_hits[5], region_hits[6]);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
